// File: hdl/rqfi_pkg.sv
// Package for the ring queue with front insert.
// Holds sizes, command and status codes, and the control-to-datapath request struct.
// No dependencies.
package rqfi_pkg;

  localparam int DEPTH      = 256;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 9;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;

  localparam int IN_BITS    = CMD_W + ITEM_WIDTH;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STAT_W + ITEM_WIDTH + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP        = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  fill_count;
    logic              pop_ok;
  } slot_req_t;

endpackage

// File: hdl/rqfi_ram.sv
// Generic single-port RAM with registered read data.
// One write or one read per cycle; read data holds while no read is issued.
// No dependencies.
module rqfi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/rqfi_ctrl.sv
// Pointer and count control of the ring queue.
// Decodes one command per cycle, updates indices and count on accept, issues the slot request.
// Depends on rqfi_pkg.
module rqfi_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [rqfi_pkg::CMD_W-1:0]    command,
  input  logic [rqfi_pkg::CAP_W-1:0]    capacity,
  output rqfi_pkg::slot_req_t           req
);

  logic [rqfi_pkg::IDX_W-1:0] write_index, write_index_next;
  logic [rqfi_pkg::IDX_W-1:0] read_index, read_index_next;
  logic [rqfi_pkg::CNT_W-1:0] held_count, held_count_next;
  logic [rqfi_pkg::CNT_W-1:0] cap;
  logic [rqfi_pkg::IDX_W-1:0] cap_m1;
  logic [rqfi_pkg::IDX_W-1:0] front_index;

  // effective capacity: 0 acts as 1, above DEPTH acts as DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap = rqfi_pkg::CNT_W'(1);
    end else if (capacity > rqfi_pkg::CAP_W'(rqfi_pkg::DEPTH)) begin
      cap = rqfi_pkg::CNT_W'(rqfi_pkg::DEPTH);
    end else begin
      cap = rqfi_pkg::CNT_W'(capacity);
    end
    cap_m1 = rqfi_pkg::IDX_W'(cap - rqfi_pkg::CNT_W'(1));
  end

  always_comb begin
    if (read_index != '0 && read_index <= cap_m1) begin
      front_index = read_index - rqfi_pkg::IDX_W'(1);
    end else begin
      front_index = cap_m1;
    end
  end

  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    held_count_next  = held_count;
    req.we     = 1'b0;
    req.re     = 1'b0;
    req.addr   = read_index;
    req.status = rqfi_pkg::ST_DONE;
    req.pop_ok = 1'b0;
    case (command)
      rqfi_pkg::CMD_PUSH_BACK: begin
        if (held_count >= cap) begin
          req.status = rqfi_pkg::ST_FULL;
        end else begin
          req.we  = accept;
          req.addr = write_index;
          write_index_next = (write_index >= cap_m1) ? '0
                             : write_index + rqfi_pkg::IDX_W'(1);
          held_count_next = held_count + rqfi_pkg::CNT_W'(1);
        end
      end
      rqfi_pkg::CMD_PUSH_FRONT: begin
        if (held_count >= cap) begin
          req.status = rqfi_pkg::ST_FULL;
        end else begin
          req.we  = accept;
          req.addr = front_index;
          read_index_next = front_index;
          held_count_next = held_count + rqfi_pkg::CNT_W'(1);
        end
      end
      rqfi_pkg::CMD_POP: begin
        if (held_count == '0) begin
          req.status = rqfi_pkg::ST_EMPTY;
        end else begin
          req.re     = accept;
          req.pop_ok = 1'b1;
          read_index_next = (read_index >= cap_m1) ? '0
                            : read_index + rqfi_pkg::IDX_W'(1);
          held_count_next = held_count - rqfi_pkg::CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    req.fill_count = held_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      held_count  <= '0;
    end else if (accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      held_count  <= held_count_next;
    end
  end

endmodule

// File: hdl/ring_queue_with_front_insert.sv
// Ring queue with push at back, push at front and pop, one result per request.
// Flow: slot RAM read and stage register load at the accepting edge, then the output
// register loads when stage 1 moves. Throughput: one request per cycle, set by the single
// RAM port; input stalls only while stage 1 is full and the output register is full and held.
// Reset: indices and count cleared, capacity set to 256; slot contents undefined.
// Depends on rqfi_pkg, rqfi_ctrl, rqfi_ram.
module ring_queue_with_front_insert (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rqfi_pkg::CAP_W-1:0]          cfg_data,      // capacity
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rqfi_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // command, item_data, zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rqfi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // status, read_data, fill_count, pad
);

  logic [rqfi_pkg::CAP_W-1:0]      capacity;
  logic                            accept;
  rqfi_pkg::slot_req_t             req;
  logic [rqfi_pkg::CMD_W-1:0]      command;
  logic [rqfi_pkg::ITEM_WIDTH-1:0] item_data;
  logic [rqfi_pkg::ITEM_WIDTH-1:0] ram_rdata;

  logic                            s1_valid;
  logic [rqfi_pkg::STAT_W-1:0]     s1_status;
  logic [rqfi_pkg::CNT_W-1:0]      s1_fill;
  logic                            s1_pop;
  logic                            s1_move;

  logic [rqfi_pkg::STAT_W-1:0]     out_status;
  logic [rqfi_pkg::ITEM_WIDTH-1:0] out_data;
  logic [rqfi_pkg::CNT_W-1:0]      out_fill;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rqfi_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  assign command   = s_axis_tdata[rqfi_pkg::CMD_W-1:0];
  assign item_data = s_axis_tdata[rqfi_pkg::CMD_W +: rqfi_pkg::ITEM_WIDTH];

  // stage 1 stalls only when the output register is full and held
  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rqfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .command  (command),
    .capacity (capacity),
    .req      (req)
  );

  rqfi_ram #(
    .WIDTH (rqfi_pkg::ITEM_WIDTH),
    .DEPTH (rqfi_pkg::DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (req.we),
    .re    (req.re),
    .addr  (req.addr),
    .wdata (item_data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= req.status;
      s1_fill   <= req.fill_count;
      s1_pop    <= req.pop_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status <= s1_status;
      out_data   <= s1_pop ? ram_rdata : '0;
      out_fill   <= s1_fill;
    end
  end

  assign m_axis_tdata = rqfi_pkg::OUT_TDATA_W'({out_fill, out_data, out_status});

endmodule
